@@ hw/rtl/hsb_to_rgb_converter_macros.svh @@
// Assertion helpers for the HSB to RGB converter.
// All checks are clocked on aclk and are off while aresetn is low.
`ifndef HSB_TO_RGB_CONVERTER_MACROS_SVH
`define HSB_TO_RGB_CONVERTER_MACROS_SVH

// Same-cycle implication.
`define HSBRGB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HSBRGB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/hsbrgb_pkg.sv @@
`default_nettype none

package hsbrgb_pkg;

    localparam logic [9:0] HUE_MAX = 10'd359;
    localparam logic [6:0] PCT_MAX = 7'd99;

    // V = floor(br * 255 / 99) = (br * 2700960) >> 20, exact for br <= 99
    localparam logic [21:0] V_SCALE = 22'd2700960;
    localparam int unsigned V_SHIFT = 20;

    // floor(x / 100) = (x * 5243) >> 19, exact for x < 43690
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int unsigned SHIFT_100 = 19;

    // floor(x / 6000) = ((x >> 4) * 89479) >> 25, exact for (x >> 4) < 173855
    localparam logic [16:0] RECIP_375 = 17'd89479;
    localparam int unsigned SHIFT_375 = 25;

    localparam logic [12:0] FULL_SCALE = 13'd6000;

    typedef logic [7:0]  level_t;
    typedef logic [14:0] prod_p_t;
    typedef logic [20:0] prod_qt_t;

endpackage

`default_nettype wire

@@ hw/rtl/hsbrgb_divc.sv @@
`default_nettype none

// Constant division of the three scaled products by reciprocal multiply.
// One register stage holds the products; the shifts on the output are wiring.
module hsbrgb_divc import hsbrgb_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     en,
    input  wire prod_p_t  prod_p,
    input  wire prod_qt_t prod_q,
    input  wire prod_qt_t prod_t,
    output level_t        quo_p,
    output level_t        quo_q,
    output level_t        quo_t
);

    logic [27:0] mul_p_reg;
    logic [33:0] mul_q_reg;
    logic [33:0] mul_t_reg;
    logic [27:0] mul_p_next;
    logic [33:0] mul_q_next;
    logic [33:0] mul_t_next;

    always_comb begin
        mul_p_next = 28'(prod_p) * 28'(RECIP_100);
        // divide by 16 first, then by 375
        mul_q_next = 34'(prod_q[20:4]) * 34'(RECIP_375);
        mul_t_next = 34'(prod_t[20:4]) * 34'(RECIP_375);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mul_p_reg <= mul_p_next;
            mul_q_reg <= mul_q_next;
            mul_t_reg <= mul_t_next;
        end
    end

    assign quo_p = mul_p_reg[SHIFT_100 +: 8];
    assign quo_q = mul_q_reg[SHIFT_375 +: 8];
    assign quo_t = mul_t_reg[SHIFT_375 +: 8];

endmodule

`default_nettype wire

@@ hw/rtl/hsb_to_rgb_converter.sv @@
`default_nettype none
`include "hsb_to_rgb_converter_macros.svh"

// HSB to RGB converter: hue (degrees, clamped to 359), saturation and brightness
// (percent, clamped to 99) in, one RGB byte triple out per request. Five register
// stages (clamp and peak level, coefficients, scaling multiply, reciprocal divide,
// sector select); while the output is not stalled, a new request is taken every
// cycle. Each stage has its own valid bit and loads when it is empty or its
// successor moves, so bubbles close up under back pressure and requests are taken
// as long as any stage has room.
module hsb_to_rgb_converter import hsbrgb_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [9:0] s_hue,
    input  wire logic [6:0] s_saturation,
    input  wire logic [6:0] s_brightness,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_red,
    output logic [7:0]      m_green,
    output logic [7:0]      m_blue
);

    typedef enum logic [2:0] {
        SEC_R_TO_Y,
        SEC_Y_TO_G,
        SEC_G_TO_C,
        SEC_C_TO_B,
        SEC_B_TO_M,
        SEC_M_TO_R
    } sector_t;

    // stage enables
    logic en1, en2, en3, en4, en5;
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg, m_valid_reg;

    assign en5     = !m_valid_reg || m_ready;
    assign en4     = !vld4_reg || en5;
    assign en3     = !vld3_reg || en4;
    assign en2     = !vld2_reg || en3;
    assign en1     = !vld1_reg || en2;
    assign s_ready = en1;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            vld3_reg    <= 1'b0;
            vld4_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) vld1_reg    <= s_valid;
            if (en2) vld2_reg    <= vld1_reg;
            if (en3) vld3_reg    <= vld2_reg;
            if (en4) vld4_reg    <= vld3_reg;
            if (en5) m_valid_reg <= vld4_reg;
        end
    end

    // ---- stage 1: clamp, peak level, sector split
    logic [8:0]  hue_c;
    logic [6:0]  sat_c;
    logic [6:0]  br_c;
    logic [28:0] v_mul;
    sector_t     sec1_next;
    logic [8:0]  base1;
    logic [5:0]  rem1_next;

    sector_t     sec1_reg;
    logic [5:0]  rem1_reg;
    logic [6:0]  sat1_reg;
    level_t      v1_reg;

    always_comb begin
        hue_c = (s_hue > HUE_MAX) ? HUE_MAX[8:0] : s_hue[8:0];
        sat_c = (s_saturation > PCT_MAX) ? PCT_MAX : s_saturation;
        br_c  = (s_brightness > PCT_MAX) ? PCT_MAX : s_brightness;
        v_mul = 29'(br_c) * 29'(V_SCALE);

        if (hue_c < 9'd60)       sec1_next = SEC_R_TO_Y;
        else if (hue_c < 9'd120) sec1_next = SEC_Y_TO_G;
        else if (hue_c < 9'd180) sec1_next = SEC_G_TO_C;
        else if (hue_c < 9'd240) sec1_next = SEC_C_TO_B;
        else if (hue_c < 9'd300) sec1_next = SEC_B_TO_M;
        else                     sec1_next = SEC_M_TO_R;

        case (sec1_next)
            SEC_R_TO_Y: base1 = 9'd0;
            SEC_Y_TO_G: base1 = 9'd60;
            SEC_G_TO_C: base1 = 9'd120;
            SEC_C_TO_B: base1 = 9'd180;
            SEC_B_TO_M: base1 = 9'd240;
            default:    base1 = 9'd300;
        endcase
        rem1_next = 6'(hue_c - base1);
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            sec1_reg <= sec1_next;
            rem1_reg <= rem1_next;
            sat1_reg <= sat_c;
            v1_reg   <= v_mul[V_SHIFT +: 8];
        end
    end

    // ---- stage 2: weights for p, q, t
    logic [12:0] srem;
    logic [12:0] sinv;
    sector_t     sec2_reg;
    level_t      v2_reg;
    logic [6:0]  kp2_reg;
    logic [12:0] kq2_reg;
    logic [12:0] kt2_reg;

    always_comb begin
        srem = 13'(sat1_reg) * 13'(rem1_reg);
        sinv = 13'(sat1_reg) * 13'(6'd60 - rem1_reg);
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            sec2_reg <= sec1_reg;
            v2_reg   <= v1_reg;
            kp2_reg  <= 7'd100 - sat1_reg;
            kq2_reg  <= FULL_SCALE - srem;
            kt2_reg  <= FULL_SCALE - sinv;
        end
    end

    // ---- stage 3: scale by peak level
    sector_t  sec3_reg;
    level_t   v3_reg;
    prod_p_t  prod_p3_reg;
    prod_qt_t prod_q3_reg;
    prod_qt_t prod_t3_reg;

    always_ff @(posedge aclk) begin
        if (en3) begin
            sec3_reg    <= sec2_reg;
            v3_reg      <= v2_reg;
            prod_p3_reg <= 15'(v2_reg) * 15'(kp2_reg);
            prod_q3_reg <= 21'(v2_reg) * 21'(kq2_reg);
            prod_t3_reg <= 21'(v2_reg) * 21'(kt2_reg);
        end
    end

    // ---- stage 4: constant division
    sector_t sec4_reg;
    level_t  v4_reg;
    level_t  p4, q4, t4;

    always_ff @(posedge aclk) begin
        if (en4) begin
            sec4_reg <= sec3_reg;
            v4_reg   <= v3_reg;
        end
    end

    hsbrgb_divc u_divc (
        .aclk   (aclk),
        .en     (en4),
        .prod_p (prod_p3_reg),
        .prod_q (prod_q3_reg),
        .prod_t (prod_t3_reg),
        .quo_p  (p4),
        .quo_q  (q4),
        .quo_t  (t4)
    );

    // ---- stage 5: sector select into output register
    // black and grey fall out of the general case: V = 0, or p = q = t = V
    level_t red_next, green_next, blue_next;

    always_comb begin
        case (sec4_reg)
            SEC_R_TO_Y: begin red_next = v4_reg; green_next = t4; blue_next = p4; end
            SEC_Y_TO_G: begin red_next = q4; green_next = v4_reg; blue_next = p4; end
            SEC_G_TO_C: begin red_next = p4; green_next = v4_reg; blue_next = t4; end
            SEC_C_TO_B: begin red_next = p4; green_next = q4; blue_next = v4_reg; end
            SEC_B_TO_M: begin red_next = t4; green_next = p4; blue_next = v4_reg; end
            default:    begin red_next = v4_reg; green_next = p4; blue_next = q4; end
        endcase
    end

    logic [7:0] red_reg, green_reg, blue_reg;

    always_ff @(posedge aclk) begin
        if (en5) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_red   = red_reg;
    assign m_green = green_reg;
    assign m_blue  = blue_reg;

    `HSBRGB_ASSERT_NEXT(a_request_lands, s_valid && s_ready, vld1_reg,
                        "accepted request lost at stage 1")
    `HSBRGB_ASSERT_IMPL(a_rem_range, vld1_reg, rem1_reg <= 6'd59, "hue remainder out of range")
    `HSBRGB_ASSERT_IMPL(a_weight_range, vld2_reg,
                        kq2_reg >= 13'd159 && kt2_reg >= 13'd60 && kp2_reg >= 7'd1,
                        "p/q/t weight out of range")
    `HSBRGB_ASSERT_NEXT(a_stall_holds, vld4_reg && !en4,
                        vld4_reg && $stable(sec4_reg) && $stable(v4_reg),
                        "stage 4 changed while stalled")

endmodule

`default_nettype wire

@@ sim/tb_hsb_to_rgb_converter.sv @@
`default_nettype none

module tb_hsb_to_rgb_converter import hsbrgb_pkg::*;;

    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned ITEMS_PER_PHASE = 485;

    typedef struct packed {
        logic [9:0] hue;
        logic [6:0] sat;
        logic [6:0] bri;
    } hsb_req_t;

    typedef struct packed {
        level_t red;
        level_t green;
        level_t blue;
    } rgb_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [9:0] s_hue;
    logic [6:0] s_saturation;
    logic [6:0] s_brightness;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_red;
    logic [7:0] m_green;
    logic [7:0] m_blue;

    hsb_req_t    pending_reqs[$];
    rgb_t        expected_rgb[$];
    hsb_req_t    next_req;
    rgb_t        want_rgb;
    logic        req_taken;
    int unsigned reqs_queued;
    int unsigned reqs_taken;
    int unsigned quiet_cycles;
    int unsigned errors;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    hsb_to_rgb_converter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_hue        (s_hue),
        .s_saturation (s_saturation),
        .s_brightness (s_brightness),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue)
    );

    function automatic rgb_t hsb_to_rgb_color(hsb_req_t req);
        int unsigned hue, sat, bri, peak, sector, rem, p, q, t;
        rgb_t        c;
        hue = (req.hue > HUE_MAX) ? HUE_MAX : req.hue;
        sat = (req.sat > PCT_MAX) ? PCT_MAX : req.sat;
        bri = (req.bri > PCT_MAX) ? PCT_MAX : req.bri;
        peak = (bri * 255) / 99;
        if (bri == 0) begin
            c = '0;
        end else if (sat == 0) begin
            c = '{peak[7:0], peak[7:0], peak[7:0]};
        end else begin
            sector = hue / 60;
            rem = hue % 60;
            p = (peak * (100 - sat)) / 100;
            q = (peak * (6000 - sat * rem)) / 6000;
            t = (peak * (6000 - sat * (60 - rem))) / 6000;
            case (sector)
                0: c = '{peak[7:0], t[7:0], p[7:0]};
                1: c = '{q[7:0], peak[7:0], p[7:0]};
                2: c = '{p[7:0], peak[7:0], t[7:0]};
                3: c = '{p[7:0], q[7:0], peak[7:0]};
                4: c = '{t[7:0], p[7:0], peak[7:0]};
                default: c = '{peak[7:0], p[7:0], q[7:0]};
            endcase
        end
        return c;
    endfunction

    task automatic queue_request(input int unsigned hue, input int unsigned sat,
                                 input int unsigned bri);
        pending_reqs.push_back('{hue[9:0], sat[6:0], bri[6:0]});
        reqs_queued++;
    endtask

    // Mostly in-range colors, with sector edges, full-range noise and clamped values.
    task automatic queue_random_requests(input int unsigned count);
        int unsigned hue, sat, bri;
        for (int unsigned i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0: hue = $urandom_range(0, 1023);
                1: hue = 60 * $urandom_range(1, 5) + $urandom_range(0, 2) - 1;
                default: hue = $urandom_range(0, 359);
            endcase
            case ($urandom_range(0, 15))
                0: sat = 0;
                1, 2: sat = $urandom_range(0, 127);
                default: sat = $urandom_range(1, 99);
            endcase
            case ($urandom_range(0, 15))
                0: bri = 0;
                1, 2: bri = $urandom_range(0, 127);
                default: bri = $urandom_range(1, 99);
            endcase
            queue_request(hue, sat, bri);
        end
    endtask

    task automatic check_level(input string name, input level_t want, input level_t got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic wait_all_taken();
        do @(negedge aclk);
        while (reqs_taken != reqs_queued || expected_rgb.size() != 0);
    endtask

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Request driver: payload and valid move at the falling edge.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || req_taken) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_req = pending_reqs.pop_front();
                    s_hue <= next_req.hue;
                    s_saturation <= next_req.sat;
                    s_brightness <= next_req.bri;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: predicts on each taken request, checks each taken result.
    always @(posedge aclk) begin
        req_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (s_valid && s_ready) begin
                expected_rgb.push_back(hsb_to_rgb_color('{s_hue, s_saturation, s_brightness}));
                reqs_taken++;
            end
            if (m_valid && m_ready) begin
                if (expected_rgb.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d",
                             $time, m_red, m_green, m_blue);
                    errors++;
                end else begin
                    want_rgb = expected_rgb.pop_front();
                    check_level("red", want_rgb.red, m_red);
                    check_level("green", want_rgb.green, m_green);
                    check_level("blue", want_rgb.blue, m_blue);
                end
            end
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_hue = '0;
        s_saturation = '0;
        s_brightness = '0;
        m_ready = 1'b0;
        req_taken = 1'b0;
        reqs_queued = 0;
        reqs_taken = 0;
        quiet_cycles = 0;
        errors = 0;
        send_idle_pct = 20;
        recv_idle_pct = 56;

        // Sector edges at full saturation and brightness, then clamping and the
        // black and grey cases.
        queue_request(0, 99, 99);
        queue_request(59, 99, 99);
        queue_request(60, 99, 99);
        queue_request(119, 99, 99);
        queue_request(120, 99, 99);
        queue_request(179, 99, 99);
        queue_request(180, 99, 99);
        queue_request(239, 99, 99);
        queue_request(240, 99, 99);
        queue_request(299, 99, 99);
        queue_request(300, 99, 99);
        queue_request(359, 99, 99);
        queue_request(360, 99, 99);
        queue_request(1023, 127, 127);
        queue_request(512, 100, 100);
        queue_request(200, 0, 50);
        queue_request(200, 0, 127);
        queue_request(200, 80, 0);
        queue_request(1023, 127, 0);
        queue_request(0, 0, 0);
        queue_request(30, 1, 1);
        queue_request(90, 50, 1);
        queue_request(341, 127, 64);

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        queue_random_requests(ITEMS_PER_PHASE);
        wait_all_taken();

        send_idle_pct = 56;
        recv_idle_pct = 20;
        queue_random_requests(ITEMS_PER_PHASE);
        wait_all_taken();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_requests(ITEMS_PER_PHASE);
        wait_all_taken();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_rgb.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_rgb.size());
            errors++;
        end
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/hsbrgb_pkg.sv
hw/rtl/hsbrgb_divc.sv
hw/rtl/hsb_to_rgb_converter.sv
sim/tb_hsb_to_rgb_converter.sv
